// ===== sv/source_code_tokenizer_top_assert.svh =====
// assertion macros shared by the tokenizer checker
// no dependencies
`ifndef SOURCE_CODE_TOKENIZER_TOP_ASSERT_SVH
`define SOURCE_CODE_TOKENIZER_TOP_ASSERT_SVH
// implication checked on every clock edge outside reset
`define SCT_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("tokenizer check failed");
// next-cycle implication
`define SCT_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("tokenizer check failed");
`endif

// ===== sv/sct_pkg.sv =====
// shared types, codes and character classes for the tokenizer
// no dependencies
`timescale 1ns / 1ps
package sct_pkg;
    localparam int LINE_BITS_DEF   = 20;
    localparam int COLUMN_BITS_DEF = 16;
    localparam int OFFSET_BITS_DEF = 32;
    localparam int LENGTH_BITS     = 16;

    localparam logic [3:0] M_IDLE    = 4'd0;
    localparam logic [3:0] M_COMMENT = 4'd1;
    localparam logic [3:0] M_WORD    = 4'd2;
    localparam logic [3:0] M_ZERO    = 4'd3;
    localparam logic [3:0] M_DEC     = 4'd4;
    localparam logic [3:0] M_HEX     = 4'd5;
    localparam logic [3:0] M_DOT     = 4'd6;
    localparam logic [3:0] M_FRAC    = 4'd7;
    localparam logic [3:0] M_EXP     = 4'd8;
    localparam logic [3:0] M_EXPSIGN = 4'd9;
    localparam logic [3:0] M_EXPDIG  = 4'd10;
    localparam logic [3:0] M_OP      = 4'd11;

    localparam logic [5:0] K_INT     = 6'd0;
    localparam logic [5:0] K_FLOAT   = 6'd1;
    localparam logic [5:0] K_WORD    = 6'd2;
    localparam logic [5:0] K_LPAREN  = 6'd3;
    localparam logic [5:0] K_RPAREN  = 6'd4;
    localparam logic [5:0] K_LBRACK  = 6'd5;
    localparam logic [5:0] K_RBRACK  = 6'd6;
    localparam logic [5:0] K_LBRACE  = 6'd7;
    localparam logic [5:0] K_RBRACE  = 6'd8;
    localparam logic [5:0] K_COMMA   = 6'd9;
    localparam logic [5:0] K_COLON   = 6'd10;
    localparam logic [5:0] K_SEMI    = 6'd11;
    localparam logic [5:0] K_DOT     = 6'd12;
    localparam logic [5:0] K_EQEQ    = 6'd13;
    localparam logic [5:0] K_ARROWEQ = 6'd14;
    localparam logic [5:0] K_ASSIGN  = 6'd15;
    localparam logic [5:0] K_BSLASH  = 6'd16;
    localparam logic [5:0] K_PLUS    = 6'd17;
    localparam logic [5:0] K_ARROW   = 6'd18;
    localparam logic [5:0] K_MINUS   = 6'd19;
    localparam logic [5:0] K_POW     = 6'd20;
    localparam logic [5:0] K_STAR    = 6'd21;
    localparam logic [5:0] K_SLASH   = 6'd22;
    localparam logic [5:0] K_PCT     = 6'd23;
    localparam logic [5:0] K_CARET   = 6'd24;
    localparam logic [5:0] K_LE      = 6'd25;
    localparam logic [5:0] K_LT      = 6'd26;
    localparam logic [5:0] K_GE      = 6'd27;
    localparam logic [5:0] K_GT      = 6'd28;
    localparam logic [5:0] K_NE      = 6'd29;
    localparam logic [5:0] K_NOT     = 6'd30;
    localparam logic [5:0] K_ANDAND  = 6'd31;
    localparam logic [5:0] K_OROR    = 6'd32;
    localparam logic [5:0] K_UNKNOWN = 6'd33;
    localparam logic [5:0] K_END     = 6'd34;

    localparam logic [2:0] E_NONE  = 3'd0;
    localparam logic [2:0] E_EXP   = 3'd1;
    localparam logic [2:0] E_AMP   = 3'd2;
    localparam logic [2:0] E_BAR   = 3'd3;
    localparam logic [2:0] E_STRAY = 3'd4;

    localparam int MAX_TOKENS = 3;

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction
    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction
    function automatic logic is_hex(input logic [7:0] c);
        return is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction
    function automatic logic is_exp(input logic [7:0] c);
        return c == "e" || c == "E";
    endfunction
endpackage

// ===== sv/sct_stream_if.sv =====
// valid/ready stream interface for tokenizer channels
// depends on nothing but the payload type given as parameter
`timescale 1ns / 1ps
interface sct_stream_if #(parameter type payload_t = logic [8:0]);
    logic     valid;
    logic     ready;
    payload_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ===== sv/sct_scan.sv =====
// per-byte scan logic: next state and up to three tokens
// depends on sct_pkg
`timescale 1ns / 1ps
module sct_scan
    import sct_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic [7:0]             c,
    input  logic                   end_mark,
    input  logic [3:0]             mode,
    input  logic [7:0]             held,
    input  logic [LINE_BITS-1:0]   ts_line,
    input  logic [COLUMN_BITS-1:0] ts_col,
    input  logic [OFFSET_BITS-1:0] ts_off,
    input  logic [LENGTH_BITS-1:0] tcount,
    input  logic [LINE_BITS-1:0]   cur_line,
    input  logic [COLUMN_BITS-1:0] cur_col,
    input  logic [OFFSET_BITS-1:0] cur_off,
    input  logic                   exp_fault,
    input  logic [COLUMN_BITS-1:0] dot_col,
    input  logic [OFFSET_BITS-1:0] dot_off,
    output logic [3:0]             mode_n,
    output logic [7:0]             held_n,
    output logic [LINE_BITS-1:0]   ts_line_n,
    output logic [COLUMN_BITS-1:0] ts_col_n,
    output logic [OFFSET_BITS-1:0] ts_off_n,
    output logic [LENGTH_BITS-1:0] tcount_n,
    output logic [LINE_BITS-1:0]   cur_line_n,
    output logic [COLUMN_BITS-1:0] cur_col_n,
    output logic [OFFSET_BITS-1:0] cur_off_n,
    output logic                   exp_fault_n,
    output logic [COLUMN_BITS-1:0] dot_col_n,
    output logic [OFFSET_BITS-1:0] dot_off_n,
    output logic [1:0]             tok_n,
    output logic [5:0]             kind   [MAX_TOKENS],
    output logic [LINE_BITS-1:0]   line   [MAX_TOKENS],
    output logic [COLUMN_BITS-1:0] col    [MAX_TOKENS],
    output logic [OFFSET_BITS-1:0] off    [MAX_TOKENS],
    output logic [LENGTH_BITS-1:0] len    [MAX_TOKENS],
    output logic [2:0]             err    [MAX_TOKENS]
);
    logic [LENGTH_BITS-1:0] inc1, inc2;
    logic taken, fl;
    logic [5:0] pk;
    logic pk_ok;

    assign inc1 = (&tcount) ? tcount : tcount + 1'b1;
    assign inc2 = (&inc1) ? inc1 : inc1 + 1'b1;

    always_comb
    begin
        pk_ok = 1'b1;
        pk = K_UNKNOWN;
        if (held == "-" && c == ">") pk = K_ARROW;
        else if (held == "=" && c == "=") pk = K_EQEQ;
        else if (held == "=" && c == ">") pk = K_ARROWEQ;
        else if (held == "*" && c == "*") pk = K_POW;
        else if (held == "<" && c == "=") pk = K_LE;
        else if (held == ">" && c == "=") pk = K_GE;
        else if (held == "!" && c == "=") pk = K_NE;
        else if (held == "&" && c == "&") pk = K_ANDAND;
        else if (held == "|" && c == "|") pk = K_OROR;
        else pk_ok = 1'b0;
    end

    always_comb
    begin
        logic [5:0] k;
        logic [2:0] e;
        mode_n = mode; held_n = held;
        ts_line_n = ts_line; ts_col_n = ts_col; ts_off_n = ts_off; tcount_n = tcount;
        cur_line_n = cur_line; cur_col_n = cur_col; cur_off_n = cur_off;
        exp_fault_n = exp_fault; dot_col_n = dot_col; dot_off_n = dot_off;
        tok_n = 2'd0;
        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            kind[i] = K_END; line[i] = ts_line; col[i] = ts_col; off[i] = ts_off;
            len[i] = tcount; err[i] = E_NONE;
        end
        taken = 1'b0;
        fl = 1'b0;
        k = K_UNKNOWN;
        e = E_NONE;

        // extend pending token
        if (!end_mark)
        begin
            unique case (mode)
                M_IDLE: taken = 1'b0;
                M_COMMENT:
                begin
                    taken = 1'b1;
                    if (c == "\n") begin mode_n = M_IDLE; held_n = '0; exp_fault_n = 1'b0; end
                end
                M_WORD:
                    if (is_alpha(c) || is_dig(c) || c == "_") begin tcount_n = inc1; taken = 1'b1; end
                M_ZERO, M_DEC:
                    if (mode == M_ZERO && (c == "x" || c == "X"))
                    begin tcount_n = inc1; mode_n = M_HEX; taken = 1'b1; end
                    else if (is_dig(c)) begin tcount_n = inc1; mode_n = M_DEC; taken = 1'b1; end
                    else if (c == ".")
                    begin dot_col_n = cur_col; dot_off_n = cur_off; mode_n = M_DOT; taken = 1'b1; end
                    else if (is_exp(c))
                    begin tcount_n = inc1; exp_fault_n = 1'b1; mode_n = M_EXP; taken = 1'b1; end
                M_HEX:
                    if (is_hex(c)) begin tcount_n = inc1; taken = 1'b1; end
                M_DOT:
                    if (is_dig(c)) begin tcount_n = inc2; mode_n = M_FRAC; taken = 1'b1; end
                M_FRAC:
                    if (is_dig(c)) begin tcount_n = inc1; taken = 1'b1; end
                    else if (is_exp(c))
                    begin tcount_n = inc1; exp_fault_n = 1'b1; mode_n = M_EXP; taken = 1'b1; end
                M_EXP, M_EXPSIGN, M_EXPDIG:
                    if (mode == M_EXP && (c == "+" || c == "-"))
                    begin tcount_n = inc1; mode_n = M_EXPSIGN; taken = 1'b1; end
                    else if (is_dig(c))
                    begin tcount_n = inc1; exp_fault_n = 1'b0; mode_n = M_EXPDIG; taken = 1'b1; end
                M_OP:
                    if (held == "-" && c == "-")
                    begin mode_n = M_COMMENT; held_n = '0; exp_fault_n = 1'b0; taken = 1'b1; end
                    else if (pk_ok)
                    begin
                        kind[0] = pk; len[0] = LENGTH_BITS'(2); tok_n = 2'd1;
                        tcount_n = LENGTH_BITS'(2);
                        mode_n = M_IDLE; held_n = '0; exp_fault_n = 1'b0; taken = 1'b1;
                    end
                default: taken = 1'b0;
            endcase
            fl = !taken && mode != M_IDLE;
        end else
            fl = 1'b1;

        // flush pending token
        if (fl)
        begin
            unique case (mode)
                M_WORD: begin kind[0] = K_WORD; tok_n = 2'd1; end
                M_ZERO, M_DEC, M_HEX: begin kind[0] = K_INT; tok_n = 2'd1; end
                M_DOT:
                begin
                    kind[0] = K_INT;
                    kind[1] = K_DOT; col[1] = dot_col; off[1] = dot_off;
                    len[1] = LENGTH_BITS'(1);
                    tok_n = 2'd2;
                end
                M_FRAC, M_EXP, M_EXPSIGN, M_EXPDIG:
                begin kind[0] = K_FLOAT; err[0] = exp_fault ? E_EXP : E_NONE; tok_n = 2'd1; end
                M_OP:
                begin
                    kind[0] = K_UNKNOWN;
                    priority case (held)
                        "-": kind[0] = K_MINUS;
                        "=": kind[0] = K_ASSIGN;
                        "*": kind[0] = K_STAR;
                        "<": kind[0] = K_LT;
                        ">": kind[0] = K_GT;
                        "!": kind[0] = K_NOT;
                        "&": err[0] = E_AMP;
                        "|": err[0] = E_BAR;
                        default: err[0] = E_STRAY;
                    endcase
                    tok_n = 2'd1;
                end
                default: tok_n = 2'd0;
            endcase
            mode_n = M_IDLE; held_n = '0; exp_fault_n = 1'b0;
        end

        if (end_mark)
        begin
            kind[tok_n] = K_END; line[tok_n] = cur_line; col[tok_n] = cur_col;
            off[tok_n] = cur_off; len[tok_n] = '0; err[tok_n] = E_NONE;
            tok_n = tok_n + 2'd1;
            mode_n = M_IDLE; held_n = '0; exp_fault_n = 1'b0;
            ts_line_n = LINE_BITS'(1); ts_col_n = COLUMN_BITS'(1); ts_off_n = '0;
            tcount_n = '0;
            cur_line_n = LINE_BITS'(1); cur_col_n = COLUMN_BITS'(1); cur_off_n = '0;
            dot_col_n = COLUMN_BITS'(1); dot_off_n = '0;
        end else
        begin
            // begin a new token
            if (!taken && !(c == " " || c == "\t" || c == 8'h0d || c == "\n"))
            begin
                ts_line_n = cur_line; ts_col_n = cur_col; ts_off_n = cur_off;
                tcount_n = LENGTH_BITS'(1);
                k = K_UNKNOWN; e = E_NONE;
                if (is_dig(c)) mode_n = (c == "0") ? M_ZERO : M_DEC;
                else if (is_alpha(c) || c == "_") mode_n = M_WORD;
                else
                begin
                    priority case (c)
                        "(": k = K_LPAREN;  ")": k = K_RPAREN;
                        "[": k = K_LBRACK;  "]": k = K_RBRACK;
                        "{": k = K_LBRACE;  "}": k = K_RBRACE;
                        ",": k = K_COMMA;   ":": k = K_COLON;
                        ";": k = K_SEMI;    ".": k = K_DOT;
                        "\\": k = K_BSLASH; "+": k = K_PLUS;
                        "/": k = K_SLASH;   "%": k = K_PCT;
                        "^": k = K_CARET;
                        "-", "=", "*", "<", ">", "!", "&", "|":
                        begin mode_n = M_OP; held_n = c; end
                        default: e = E_STRAY;
                    endcase
                    if (mode_n != M_OP)
                    begin
                        kind[tok_n] = k; line[tok_n] = cur_line; col[tok_n] = cur_col;
                        off[tok_n] = cur_off; len[tok_n] = LENGTH_BITS'(1); err[tok_n] = e;
                        tok_n = tok_n + 2'd1;
                    end
                end
            end
            cur_off_n = (&cur_off) ? cur_off : cur_off + 1'b1;
            if (c == "\n")
            begin
                cur_line_n = (&cur_line) ? cur_line : cur_line + 1'b1;
                cur_col_n = COLUMN_BITS'(1);
            end else
                cur_col_n = (&cur_col) ? cur_col : cur_col + 1'b1;
        end
    end
endmodule

// ===== sv/sct_out_queue.sv =====
// token output queue: takes up to three tokens a cycle, sends one a beat
// depends on sct_pkg
`timescale 1ns / 1ps
module sct_out_queue
    import sct_pkg::*;
#(
    parameter int WIDTH = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_n,
    input  logic [WIDTH-1:0] push_data [MAX_TOKENS],
    output logic             room,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);
    localparam int DEPTH = 8;
    logic [WIDTH-1:0] mem [DEPTH];
    logic [2:0] wp_reg, rp_reg;
    logic [3:0] cnt_reg, cnt_next;
    logic pop;

    assign out_valid = cnt_reg != 4'd0;
    assign out_data = mem[rp_reg];
    assign pop = out_valid && out_ready;
    // enough room for a worst-case burst
    assign room = cnt_reg <= 4'(DEPTH - MAX_TOKENS);
    assign cnt_next = cnt_reg + {2'b0, push_n} - {3'b0, pop};

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_TOKENS; i++)
            if (2'(i) < push_n) mem[wp_reg + 3'(i)] <= push_data[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else
        begin
            wp_reg <= wp_reg + {1'b0, push_n};
            rp_reg <= rp_reg + {2'b0, pop};
            cnt_reg <= cnt_next;
        end
    end
endmodule

// ===== sv/source_code_tokenizer_top.sv =====
// tokenizer top: one source byte per beat, tokens out through a queue
// path: the byte that ends a token is registered, scanned, and its tokens are written into the queue before leaving
// throughput: one byte per cycle; a byte may yield up to three tokens, queued
// output drains one token per cycle while out_ch.ready is high; input stalls when the queue lacks room
// reset: asynchronous active-low, returns scanner to line 1, column 1, offset 0
// depends on sct_pkg, sct_stream_if, sct_scan, sct_out_queue
`timescale 1ns / 1ps
module source_code_tokenizer_top
    import sct_pkg::*;
#(
    parameter int LINE_BITS   = LINE_BITS_DEF,
    parameter int COLUMN_BITS = COLUMN_BITS_DEF,
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input logic clk,
    input logic rst_n,
    sct_stream_if.sink   in_ch,
    sct_stream_if.source out_ch
);
    localparam int TW = 6 + LINE_BITS + COLUMN_BITS + OFFSET_BITS + LENGTH_BITS + 3;

    // input register stage
    logic       iv_reg;
    logic [7:0] ib_reg;
    logic       ie_reg;
    logic       room, advance;

    // scan state
    logic [3:0]             mode_reg, mode_next;
    logic [7:0]             held_reg, held_next;
    logic [LINE_BITS-1:0]   tsl_reg, tsl_next, cl_reg, cl_next;
    logic [COLUMN_BITS-1:0] tsc_reg, tsc_next, cc_reg, cc_next, dc_reg, dc_next;
    logic [OFFSET_BITS-1:0] tso_reg, tso_next, co_reg, co_next, do_reg, do_next;
    logic [LENGTH_BITS-1:0] cnt_reg, cnt_next;
    logic                   ef_reg, ef_next;

    logic [1:0]             tok_n;
    logic [5:0]             kind [MAX_TOKENS];
    logic [LINE_BITS-1:0]   line [MAX_TOKENS];
    logic [COLUMN_BITS-1:0] col  [MAX_TOKENS];
    logic [OFFSET_BITS-1:0] off  [MAX_TOKENS];
    logic [LENGTH_BITS-1:0] len  [MAX_TOKENS];
    logic [2:0]             err  [MAX_TOKENS];
    logic [TW-1:0]          pdata [MAX_TOKENS];
    logic [TW:0]            qdata [MAX_TOKENS];
    logic [TW:0]            qout;
    logic                   qvalid;

    // registered byte moves on when the queue can take its worst-case burst
    assign advance = room;
    assign in_ch.ready = !iv_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            iv_reg <= 1'b0;
        else if (in_ch.ready)
            iv_reg <= in_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            ib_reg <= in_ch.payload.source_byte;
            ie_reg <= in_ch.payload.end_mark;
        end
    end

    sct_scan #(
        .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS), .OFFSET_BITS(OFFSET_BITS)
    ) u_scan (
        .c(ib_reg), .end_mark(ie_reg), .mode(mode_reg), .held(held_reg),
        .ts_line(tsl_reg), .ts_col(tsc_reg), .ts_off(tso_reg), .tcount(cnt_reg),
        .cur_line(cl_reg), .cur_col(cc_reg), .cur_off(co_reg), .exp_fault(ef_reg),
        .dot_col(dc_reg), .dot_off(do_reg),
        .mode_n(mode_next), .held_n(held_next), .ts_line_n(tsl_next),
        .ts_col_n(tsc_next), .ts_off_n(tso_next), .tcount_n(cnt_next),
        .cur_line_n(cl_next), .cur_col_n(cc_next), .cur_off_n(co_next),
        .exp_fault_n(ef_next), .dot_col_n(dc_next), .dot_off_n(do_next),
        .tok_n(tok_n), .kind(kind), .line(line), .col(col), .off(off),
        .len(len), .err(err)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE; held_reg <= '0; ef_reg <= 1'b0;
            tsl_reg <= LINE_BITS'(1); tsc_reg <= COLUMN_BITS'(1); tso_reg <= '0;
            cnt_reg <= '0;
            cl_reg <= LINE_BITS'(1); cc_reg <= COLUMN_BITS'(1); co_reg <= '0;
            dc_reg <= COLUMN_BITS'(1); do_reg <= '0;
        end else if (iv_reg && advance)
        begin
            mode_reg <= mode_next; held_reg <= held_next; ef_reg <= ef_next;
            tsl_reg <= tsl_next; tsc_reg <= tsc_next; tso_reg <= tso_next;
            cnt_reg <= cnt_next;
            cl_reg <= cl_next; cc_reg <= cc_next; co_reg <= co_next;
            dc_reg <= dc_next; do_reg <= do_next;
        end
    end

    // pack tokens; last_of_run marks the final token of this byte
    always_comb
    begin
        for (int i = 0; i < MAX_TOKENS; i++)
        begin
            pdata[i] = {kind[i], line[i], col[i], off[i], len[i], err[i]};
            qdata[i] = {pdata[i], (2'(i + 1) == tok_n)};
        end
    end

    sct_out_queue #(.WIDTH(TW + 1)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push_n((iv_reg && advance) ? tok_n : 2'd0),
        .push_data(qdata), .room(room),
        .out_valid(qvalid), .out_ready(out_ch.ready), .out_data(qout)
    );

    assign out_ch.valid = qvalid;
    always_comb
    begin
        out_ch.payload.token_kind   = qout[TW -: 6];
        out_ch.payload.start_line   = 20'(qout[TW-6 -: LINE_BITS]);
        out_ch.payload.start_column = 16'(qout[TW-6-LINE_BITS -: COLUMN_BITS]);
        out_ch.payload.start_offset =
            32'(qout[TW-6-LINE_BITS-COLUMN_BITS -: OFFSET_BITS]);
        out_ch.payload.token_length = qout[19:4];
        out_ch.payload.error_code   = qout[3:1];
        out_ch.payload.last_of_run  = qout[0];
    end
endmodule

// ===== sv/sct_checker.sv =====
// port-level checker for the tokenizer, bound to the top level
// depends on sct_pkg and source_code_tokenizer_top_assert.svh
`timescale 1ns / 1ps
`include "source_code_tokenizer_top_assert.svh"
module sct_checker
    import sct_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [5:0] token_kind,
    input logic [2:0] error_code,
    input logic [15:0] token_length,
    input logic       last_of_run
);
    `SCT_ASSERT_IMPL(a_end_last, clk, rst_n, out_valid && token_kind == K_END, last_of_run)
    `SCT_ASSERT_IMPL(a_end_len, clk, rst_n, out_valid && token_kind == K_END,
        token_length == 16'd0)
    `SCT_ASSERT_IMPL(a_err_kind, clk, rst_n,
        out_valid && (error_code == E_AMP || error_code == E_BAR || error_code == E_STRAY),
        token_kind == K_UNKNOWN)
    `SCT_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid)
endmodule

bind source_code_tokenizer_top sct_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .token_kind(out_ch.payload.token_kind), .error_code(out_ch.payload.error_code),
    .token_length(out_ch.payload.token_length), .last_of_run(out_ch.payload.last_of_run)
);
